// ----- design/ifst_pkg.sv -----
// Shared types, constants and the frame builder for the id frame serial transmitter.
`timescale 1ns / 1ps

package ifst_pkg;

  localparam int FRAME_W = 64;
  localparam int CNT_W   = $clog2(FRAME_W + 1);
  localparam int ID_W    = 16;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 8;

  localparam logic [31:0] FRAME_HI_BASE = 32'hD950_0830;
  localparam logic [31:0] FRAME_LO_BASE = 32'h0000_100D;
  localparam logic [7:0]  CHK_SEED      = 8'hE8;

  // Input word kinds carried on tuser.
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  // Bit phase; the encoding follows the countdown put, rise, fall.
  typedef enum logic [1:0] {
    PH_FALL = 2'd1,
    PH_RISE = 2'd2,
    PH_PUT  = 2'd3
  } phase_t;

  // Control from the sequencer to the row of frame cells.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // One result word.
  typedef struct packed {
    logic done_res;
    logic busy_res;
    logic clock_line;
    logic data_line;
  } result_t;

  function automatic logic [FRAME_W-1:0] build_frame(input logic [ID_W-1:0] id);
    logic [7:0]  chk;
    logic [31:0] hi;
    logic [31:0] lo;
    chk = CHK_SEED ^ id[15:8] ^ id[7:0];
    hi  = FRAME_HI_BASE | {28'd0, id[15:12]};
    lo  = FRAME_LO_BASE | {id[11:0], 20'd0} | {20'd0, chk, 4'd0};
    return {hi, lo};
  endfunction

endpackage

// ----- design/ifst_bit_cell.sv -----
// One cell of the frame shift row: holds a single frame bit.
`timescale 1ns / 1ps

module ifst_bit_cell
  import ifst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      load_bit,
  input  logic      shift_in,
  output logic      bit_q
);

  logic bit_r;
  logic bit_nxt;

  // Load wins over shift; a start word replaces the whole frame.
  always_comb begin
    bit_nxt = bit_r;
    if (ctl.load) begin
      bit_nxt = load_bit;
    end else if (ctl.shift) begin
      bit_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else begin
      bit_r <= bit_nxt;
    end
  end

  assign bit_q = bit_r;

endmodule

// ----- design/ifst_ctrl.sv -----
// Bit sequencer: phase, bit count and the data and clock pin levels.
`timescale 1ns / 1ps

module ifst_ctrl
  import ifst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  kind_t     kind,
  input  logic      frame_msb,
  output cell_ctl_t cell_ctl,
  output result_t   result
);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             sending_r, sending_nxt;
  logic             data_r, data_nxt;
  logic             clock_r, clock_nxt;
  logic             done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PUT;
      left_r    <= '0;
      sending_r <= 1'b0;
      data_r    <= 1'b0;
      clock_r   <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      left_r    <= left_nxt;
      sending_r <= sending_nxt;
      data_r    <= data_nxt;
      clock_r   <= clock_nxt;
    end
  end

  // The next bit to send always sits in the top cell, so no bit index is needed.
  always_comb begin
    phase_nxt      = phase_r;
    left_nxt       = left_r;
    sending_nxt    = sending_r;
    data_nxt       = data_r;
    clock_nxt      = clock_r;
    done           = 1'b0;
    cell_ctl.load  = 1'b0;
    cell_ctl.shift = 1'b0;
    if (kind == KIND_START) begin
      cell_ctl.load = step;
      left_nxt      = CNT_W'(FRAME_W);
      phase_nxt     = PH_PUT;
      sending_nxt   = 1'b1;
    end else if (sending_r) begin
      if (left_r == '0) begin
        data_nxt    = 1'b0;
        sending_nxt = 1'b0;
        done        = 1'b1;
      end else begin
        unique case (phase_r)
          PH_PUT: begin
            data_nxt  = frame_msb;
            phase_nxt = PH_RISE;
          end
          PH_RISE: begin
            clock_nxt = 1'b1;
            phase_nxt = PH_FALL;
          end
          PH_FALL: begin
            clock_nxt      = 1'b0;
            phase_nxt      = PH_PUT;
            left_nxt       = left_r - CNT_W'(1);
            cell_ctl.shift = step;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
    result.data_line  = data_nxt;
    result.clock_line = clock_nxt;
    result.busy_res   = sending_nxt;
    result.done_res   = done;
  end

  // The count never runs past a full frame.
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= CNT_W'(FRAME_W))
    else $error("bit count above frame length");

  // An idle sequencer always waits in the put phase.
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> phase_r == PH_PUT)
    else $error("idle with phase not at put");

  // Done, taken on a step, ends the send and leaves the data line low.
  a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (step && done) |=> !sending_r && !data_r)
    else $error("done without ending the send");

endmodule

// ----- design/id_frame_serial_transmitter_top.sv -----
// Top level of the id frame serial transmitter: cell row, sequencer, output buffer.
`timescale 1ns / 1ps

// Usage
// The input channel takes one word per accepted handshake. in_tuser selects the
// kind of word: 0 starts a new 64-bit frame built from the 16-bit id on in_tdata,
// 1 is a timer tick that advances the bit-banged send by one step (put data,
// raise clock, lower clock per frame bit, MSB first, then one final tick that
// drives data low and flags done). A start during a send restarts it.
// Every accepted input word produces exactly one result word on the output
// channel, carrying the data and clock pin levels, busy and done.
// The result word is registered into the head entry, or into the skid entry when
// the head is still waiting. Throughput is one word per cycle while in_tready is
// high; the frame lives in a row of 64 one-bit cells that shift toward the top
// once per finished bit, so each word is a single register update.
// A two-entry output buffer (head plus skid register) lets one more input word
// be accepted while a result waits; when the receiver stalls long enough to fill
// both entries, in_tready drops until the head word is taken.
// Synchronous reset clears the pins, the frame and the buffer; the block is idle
// with no result pending afterwards.

module id_frame_serial_transmitter_top
  import ifst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [TDATA_IN_W-1:0]  in_tdata,   // [15:0] id
  input  logic                   in_tuser,   // [0] kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [TDATA_OUT_W-1:0] out_tdata   // [0] data_line, [1] clock_line,
                                             // [2] busy_res, [3] done_res, [7:4] zero
);

  logic               push;
  logic               pop;
  cell_ctl_t          cell_ctl;
  result_t            result;
  logic [FRAME_W-1:0] frame_load;
  logic [FRAME_W-1:0] frame_q;

  logic    head_vld_r, head_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t head_r, head_nxt;
  result_t skid_r, skid_nxt;

  assign in_tready = !skid_vld_r;
  assign push      = in_tvalid && in_tready;
  assign pop       = head_vld_r && out_tready;

  assign frame_load = build_frame(in_tdata[ID_W-1:0]);

  // Cell 0 holds the frame LSB; each bit moves up one cell per finished bit.
  for (genvar i = 0; i < FRAME_W; i++) begin : g_cell
    if (i == 0) begin : g_first
      ifst_bit_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cell_ctl),
        .load_bit (frame_load[i]),
        .shift_in (1'b0),
        .bit_q    (frame_q[i])
      );
    end else begin : g_rest
      ifst_bit_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cell_ctl),
        .load_bit (frame_load[i]),
        .shift_in (frame_q[i-1]),
        .bit_q    (frame_q[i])
      );
    end
  end

  ifst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (push),
    .kind      (kind_t'(in_tuser)),
    .frame_msb (frame_q[FRAME_W-1]),
    .cell_ctl  (cell_ctl),
    .result    (result)
  );

  // Output buffer: a new word goes to the head when it frees up, else to the skid.
  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (pop) begin
        head_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_vld_r || pop) begin
        head_nxt     = result;
        head_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = result;
        skid_vld_nxt = 1'b1;
      end
    end else if (pop) begin
      head_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = head_vld_r;
  assign out_tdata  = {{(TDATA_OUT_W - 4){1'b0}}, head_r};

  // The skid entry is only ever filled behind a waiting head word.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> head_vld_r)
    else $error("skid entry valid with empty head");

  // A word that ends the send never reports busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (head_vld_r && head_r.done_res) |-> !head_r.busy_res)
    else $error("done word still marked busy");

  // With both entries full, a pop moves the skid word into the head.
  a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && out_tready) |=> (head_vld_r && !skid_vld_r &&
                                    head_r == $past(skid_r)))
    else $error("skid word not forwarded to head");

endmodule
